/* rtl/wrrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrc_pkg
// types, codes and constants shared by the rotation range command generator
// ----------------------------------------------------------------------------
package wrrc_pkg;

  localparam int RangeW  = 12;
  localparam int DegW    = 10;
  localparam int NumW    = 21;
  localparam int RecipW  = 25;
  localparam int RecipSh = 32;
  localparam int StartW  = 12;

  localparam logic [RangeW-1:0] RANGE_MIN      = 12'd40;
  localparam logic [RangeW-1:0] RANGE_MAX      = 12'd900;
  localparam logic [DegW-1:0]   FULL_LOW       = 10'd200;
  localparam logic [DegW-1:0]   FULL_HIGH      = 10'd900;
  localparam logic [DegW-1:0]   CLAMP_LOW_DEG  = 10'd40;

  // floor(2^32 / full range), good to one count of the quotient
  localparam logic [RecipW-1:0] RECIP_900 = 25'd4772185;
  localparam logic [RecipW-1:0] RECIP_200 = 25'd21474836;

  // wheel models
  localparam logic [1:0] MODEL_DIRECT      = 2'd0;
  localparam logic [1:0] MODEL_COARSE_FINE = 2'd1;

  // status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_CLAMP_UP    = 2'd1;
  localparam logic [1:0] ST_CLAMP_DOWN  = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  // report bytes
  localparam logic [7:0] CMD_EXT        = 8'hf8;
  localparam logic [7:0] SUB_RANGE      = 8'h81;
  localparam logic [7:0] SEL_FULL_900   = 8'h03;
  localparam logic [7:0] SEL_FULL_200   = 8'h02;
  localparam logic [7:0] CMD_FINE       = 8'h81;
  localparam logic [7:0] SUB_FINE       = 8'h0b;
  localparam logic [7:0] BYTE_FILL      = 8'hff;
  localparam logic [StartW-1:0] START_TOP = 12'hfff;

  localparam int QueueDepthDef = 2;
  localparam int OutDepthDef   = 2;

  // classified request between front and back
  typedef struct packed {
    logic [1:0]      model;
    logic [1:0]      status;
    logic [DegW-1:0] range;
    logic            full_900;
    logic            exact;
    logic [NumW-1:0] num;
  } cmd_t;

  // one command report word
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b5;
    logic [7:0] b6;
    logic       last;
    logic [1:0] status;
  } report_t;

endpackage

/* rtl/wrrc_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrc_fifo
// small register queue, head word shown while not empty
// ----------------------------------------------------------------------------
module wrrc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CntFull);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/wrrc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrc_front
// model register, request clamp and classification, scaled numerator
// ----------------------------------------------------------------------------
module wrrc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wheel_model_we,
  input  logic [1:0]                    wheel_model_wdata,
  input  logic                          push,
  output logic                          full,
  input  logic [wrrc_pkg::RangeW-1:0]   requested_range,
  output logic                          cmd_wr,
  output wrrc_pkg::cmd_t                cmd_data,
  input  logic                          cmd_full
);
  import wrrc_pkg::*;

  logic [1:0]      wheel_model;
  logic            valid;
  cmd_t            cmd;
  cmd_t            cmd_next;
  logic            load;
  logic [DegW-1:0] clamped;
  logic [1:0]      clamp_st;
  logic [DegW-1:0] full_deg;
  logic [DegW-1:0] span;

  assign full     = valid && cmd_full;
  assign load     = push && !full;
  assign cmd_wr   = valid && !cmd_full;
  assign cmd_data = cmd;

  always_comb begin
    if (requested_range < RANGE_MIN) begin
      clamped  = CLAMP_LOW_DEG;
      clamp_st = ST_CLAMP_UP;
    end else if (requested_range > RANGE_MAX) begin
      clamped  = FULL_HIGH;
      clamp_st = ST_CLAMP_DOWN;
    end else begin
      clamped  = requested_range[DegW-1:0];
      clamp_st = ST_OK;
    end
    cmd_next.full_900 = (clamped > FULL_LOW);
    full_deg          = cmd_next.full_900 ? FULL_HIGH : FULL_LOW;
    // span = full - range + 1, numerator = span * 2047
    span              = full_deg - clamped + 1'b1;
    cmd_next.num      = {span, 11'b0} - {11'b0, span};
    cmd_next.exact    = (clamped == FULL_LOW) || (clamped == FULL_HIGH);
    cmd_next.range    = clamped;
    cmd_next.model    = wheel_model;
    cmd_next.status   = wheel_model[1] ? ST_UNSUPPORTED : clamp_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_model <= MODEL_DIRECT;
      valid       <= 1'b0;
    end else begin
      if (wheel_model_we) begin
        wheel_model <= wheel_model_wdata;
      end
      if (load) begin
        valid <= 1'b1;
      end else if (cmd_wr) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* rtl/wrrc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrc_back
// reciprocal divide of the start point, then one report word per cycle while the result queue has room
// ----------------------------------------------------------------------------
module wrrc_back (
  input  logic              clk,
  input  logic              rst,
  input  wrrc_pkg::cmd_t    cmd_data,
  input  logic              cmd_empty,
  output logic              cmd_rd,
  output logic              rpt_wr,
  output wrrc_pkg::report_t rpt_data,
  input  logic              rpt_full
);
  import wrrc_pkg::*;

  localparam int ProdW = NumW + RecipW;
  localparam int ChkW  = StartW + DegW;

  // quotient estimate stage
  logic              valid_a;
  cmd_t              cmd_a;
  logic [StartW-1:0] q_est;
  logic [ProdW-1:0]  prod;

  // report stage
  logic              valid_b;
  cmd_t              cmd_b;
  logic [StartW-1:0] q_b;
  logic              phase;

  logic              a_free;
  logic              b_free;
  logic              a_adv;
  logic              item_done;
  logic              two_words;
  logic [ChkW-1:0]   chk;
  logic [ChkW-1:0]   rem;
  logic [DegW-1:0]   full_deg;
  logic [StartW-1:0] left;
  logic [StartW-1:0] right;
  report_t           rpt;

  assign prod = cmd_data.num * (cmd_data.full_900 ? RECIP_900 : RECIP_200);

  assign two_words = (cmd_b.model == MODEL_COARSE_FINE);
  assign rpt_wr    = valid_b && !rpt_full;
  assign item_done = rpt_wr && (!two_words || phase);
  assign b_free    = !valid_b || item_done;
  assign a_adv     = valid_a && b_free;
  assign a_free    = !valid_a || b_free;
  assign cmd_rd    = !cmd_empty && a_free;

  // estimate is exact or one low: one compare fixes it
  always_comb begin
    full_deg = cmd_b.full_900 ? FULL_HIGH : FULL_LOW;
    chk      = q_b * full_deg;
    rem      = ChkW'(cmd_b.num) - chk;
    left     = q_b + StartW'(rem >= ChkW'(full_deg));
    right    = START_TOP - left;
  end

  always_comb begin
    rpt        = '0;
    rpt.status = cmd_b.status;
    rpt.last   = 1'b1;
    case (cmd_b.model)
      MODEL_DIRECT: begin
        rpt.b0 = CMD_EXT;
        rpt.b1 = SUB_RANGE;
        rpt.b2 = cmd_b.range[7:0];
        rpt.b3 = {6'b0, cmd_b.range[DegW-1:8]};
      end
      MODEL_COARSE_FINE: begin
        if (!phase) begin
          rpt.b0   = CMD_EXT;
          rpt.b1   = cmd_b.full_900 ? SEL_FULL_900 : SEL_FULL_200;
          rpt.last = 1'b0;
        end else begin
          rpt.b0 = CMD_FINE;
          rpt.b1 = SUB_FINE;
          if (!cmd_b.exact) begin
            rpt.b2 = left[StartW-1:4];
            rpt.b3 = right[StartW-1:4];
            rpt.b4 = BYTE_FILL;
            rpt.b5 = {right[3:1], 1'b0, left[3:1], 1'b0};
            rpt.b6 = BYTE_FILL;
          end
        end
      end
      default: begin
        rpt.status = ST_UNSUPPORTED;
      end
    endcase
  end

  assign rpt_data = rpt;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
      phase   <= 1'b0;
    end else begin
      if (cmd_rd) begin
        valid_a <= 1'b1;
      end else if (a_adv) begin
        valid_a <= 1'b0;
      end
      if (a_adv) begin
        valid_b <= 1'b1;
      end else if (item_done) begin
        valid_b <= 1'b0;
      end
      if (item_done) begin
        phase <= 1'b0;
      end else if (rpt_wr) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_rd) begin
      cmd_a <= cmd_data;
      q_est <= prod[RecipSh +: StartW];
    end
    if (a_adv) begin
      cmd_b <= cmd_a;
      q_b   <= q_est;
    end
  end

endmodule

/* rtl/wheel_rotation_range_command_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_rotation_range_command_top
// clamps a requested rotation range and emits 7-byte command report words
// ----------------------------------------------------------------------------
// path: a taken request passes the front register, the command queue,
//   the estimate and report stages and the result queue to the result ports;
//   a second word (coarse plus fine model) follows the first
// throughput: one word per cycle while the result queue has room: one request
//   per cycle for single-word models, one per two words for coarse plus fine
// reset: rst is synchronous, active high; queues empty, model register 0
module wheel_rotation_range_command_top #(
  parameter int QUEUE_DEPTH = wrrc_pkg::QueueDepthDef,
  parameter int OUT_DEPTH   = wrrc_pkg::OutDepthDef
) (
  input  logic                        clk,
  input  logic                        rst,
  // model register write
  input  logic                        wheel_model_we,
  input  logic [1:0]                  wheel_model_wdata,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic [wrrc_pkg::RangeW-1:0] requested_range,
  // report side
  output logic                        empty,
  input  logic                        pop,
  output logic [7:0]                  report_byte0,
  output logic [7:0]                  report_byte1,
  output logic [7:0]                  report_byte2,
  output logic [7:0]                  report_byte3,
  output logic [7:0]                  report_byte4,
  output logic [7:0]                  report_byte5,
  output logic [7:0]                  report_byte6,
  output logic                        last_report,
  output logic [1:0]                  status
);
  import wrrc_pkg::*;

  // front to command queue
  logic    cmd_wr;
  cmd_t    cmd_in;
  logic    cmd_full;
  // command queue to back
  logic    cmd_rd;
  cmd_t    cmd_out;
  logic    cmd_empty;
  // back to result queue
  logic    rpt_wr;
  report_t rpt_in;
  logic    rpt_full;
  report_t rpt_out;

  // front: model register, clamp, classify, numerator of the start point
  wrrc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .wheel_model_we    (wheel_model_we),
    .wheel_model_wdata (wheel_model_wdata),
    .push              (push),
    .full              (full),
    .requested_range   (requested_range),
    .cmd_wr            (cmd_wr),
    .cmd_data          (cmd_in),
    .cmd_full          (cmd_full)
  );

  // short queue that decouples the front from the back
  wrrc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  // back: divide by full range, then sequence the report words
  wrrc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .rpt_wr    (rpt_wr),
    .rpt_data  (rpt_in),
    .rpt_full  (rpt_full)
  );

  // result queue, head word drives the result ports
  wrrc_fifo #(
    .WIDTH ($bits(report_t)),
    .DEPTH (OUT_DEPTH)
  ) u_rpt_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rpt_wr),
    .wr_data (rpt_in),
    .full    (rpt_full),
    .rd_en   (pop),
    .rd_data (rpt_out),
    .empty   (empty)
  );

  assign report_byte0 = rpt_out.b0;
  assign report_byte1 = rpt_out.b1;
  assign report_byte2 = rpt_out.b2;
  assign report_byte3 = rpt_out.b3;
  assign report_byte4 = rpt_out.b4;
  assign report_byte5 = rpt_out.b5;
  assign report_byte6 = rpt_out.b6;
  assign last_report  = rpt_out.last;
  assign status       = rpt_out.status;

endmodule

/* rtl/wrrc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrrc_checker
// port-level checks on the report word stream
// ----------------------------------------------------------------------------
module wrrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] report_byte0,
  input logic [7:0] report_byte1,
  input logic [7:0] report_byte2,
  input logic [7:0] report_byte3,
  input logic [7:0] report_byte4,
  input logic [7:0] report_byte5,
  input logic [7:0] report_byte6,
  input logic       last_report,
  input logic [1:0] status
);
  import wrrc_pkg::*;

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a word not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(report_byte0) && $stable(report_byte1)
      && $stable(last_report) && $stable(status)))
    else $error("waiting report word changed");

  // unsupported model gives one all-zero word
  a_unsup: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_UNSUPPORTED) |-> (last_report && report_byte0 == 8'h00
      && report_byte1 == 8'h00 && report_byte2 == 8'h00 && report_byte3 == 8'h00
      && report_byte4 == 8'h00 && report_byte5 == 8'h00 && report_byte6 == 8'h00))
    else $error("unsupported report not all zero");

  // only a coarse word is not last, and a fine word follows it
  a_coarse: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_report) |-> (report_byte0 == CMD_EXT
      && (report_byte1 == SEL_FULL_900 || report_byte1 == SEL_FULL_200)))
    else $error("malformed coarse report");

  a_fine_next: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last_report && pop) |=> (!empty || (report_byte0 == CMD_FINE)) ##0
      (empty || (report_byte0 == CMD_FINE && report_byte1 == SUB_FINE && last_report)))
    else $error("coarse report not followed by fine report");

endmodule

bind wheel_rotation_range_command_top wrrc_checker u_wrrc_checker (.*);
